// ===== rtl/tsc_pkg.sv =====
// Shared types, constants and register map of the tile slot cache.
package tsc_pkg;

	localparam int MAX_ENTRIES_DEF = 128;

	localparam int KEY_W   = 48;
	localparam int TIME_W  = 32;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int TPG_W   = 5;
	localparam int EIU_W   = 8;
	localparam int SLOT_W  = 7;
	localparam int TIDX_W  = 11;

	localparam logic [TPG_W-1:0] TPG_RESET = 5'd1;
	localparam logic [EIU_W-1:0] EIU_RESET = 8'd128;

	localparam logic REG_TILES_PER_GLYPH = 1'b0;
	localparam logic REG_ENTRIES_IN_USE  = 1'b1;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [TIME_W-1:0] stamp_t;

	typedef struct packed {
		logic signed [15:0] glyph;
		logic [3:0]         colour;
		logic [7:0]         special_flags;
		logic [7:0]         char_code;
		logic [11:0]        tile_number;
		logic [31:0]        now;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [TIDX_W-1:0] tile_index;
		logic              hit;
		logic              load_needed;
	} rsp_t;

	typedef struct packed {
		logic key_en;
		logic use_en;
	} wr_ctl_t;

endpackage

// ===== rtl/tsc_store.sv =====
// Key and last-use memories of the tile slot cache, one write and one registered read port.
module tsc_store #(
	parameter int DEPTH = tsc_pkg::MAX_ENTRIES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output tsc_pkg::key_t       rd_key,
	output tsc_pkg::stamp_t     rd_last,
	input  tsc_pkg::wr_ctl_t    wr_ctl,
	input  logic [AW-1:0]       wr_addr,
	input  tsc_pkg::key_t       wr_key,
	input  tsc_pkg::stamp_t     wr_last
);

	tsc_pkg::key_t   key_mem [DEPTH];
	tsc_pkg::stamp_t use_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_ctl.key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr_ctl.use_en) begin
			use_mem[wr_addr] <= wr_last;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key  <= key_mem[rd_addr];
			rd_last <= use_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/tile_slot_cache.sv =====
// Top level of the tile slot cache: register port, scan sequencer and result register.
// An empty glyph gives its result in the cycle after the request is taken;
// any other request gives it after a scan over the n slots in use (at most 128) and a write step.
// Requests are taken only while idle; a scan does one memory read and one age compare per slot.
// The result strobe lasts one cycle and cannot be held off.
// Reset clears all slot valid bits at once and loads the register reset values.
module tile_slot_cache #(
	parameter int MAX_ENTRIES = tsc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  tsc_pkg::req_t                req,
	output logic                         done,
	output tsc_pkg::rsp_t                rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [tsc_pkg::DATA_W-1:0]   pwdata,
	output logic [tsc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t                        state_q;
	logic [tsc_pkg::TPG_W-1:0]     tpg_q;
	logic [tsc_pkg::EIU_W-1:0]     eiu_q;
	logic [CW-1:0]                 n_entries;
	logic [CW-1:0]                 cnt_q;
	logic [MAX_ENTRIES-1:0]        valid_q;
	tsc_pkg::key_t                 key_q;
	tsc_pkg::stamp_t               now_q;
	logic                          pend_s1;
	logic                          vld_s1;
	logic [AW-1:0]                 idx_s1;
	logic                          hit_found_q;
	logic [AW-1:0]                 hit_slot_q;
	logic                          free_found_q;
	logic [AW-1:0]                 free_slot_q;
	tsc_pkg::stamp_t               best_age_q;
	logic [AW-1:0]                 best_slot_q;
	logic                          done_q;
	tsc_pkg::rsp_t                 rsp_q;
	logic                          rd_en;
	tsc_pkg::key_t                 rd_key;
	tsc_pkg::stamp_t               rd_last;
	tsc_pkg::stamp_t               age;
	logic [AW-1:0]                 sel_slot;
	logic [tsc_pkg::TIDX_W-1:0]    tile_index;
	tsc_pkg::wr_ctl_t              wr_ctl;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpg_q <= tsc_pkg::TPG_RESET;
			eiu_q <= tsc_pkg::EIU_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				tsc_pkg::REG_TILES_PER_GLYPH: tpg_q <= pwdata[tsc_pkg::TPG_W-1:0];
				tsc_pkg::REG_ENTRIES_IN_USE:  eiu_q <= pwdata[tsc_pkg::EIU_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tsc_pkg::REG_TILES_PER_GLYPH:
				prdata = {{(tsc_pkg::DATA_W-tsc_pkg::TPG_W){1'b0}}, tpg_q};
			tsc_pkg::REG_ENTRIES_IN_USE:
				prdata = {{(tsc_pkg::DATA_W-tsc_pkg::EIU_W){1'b0}}, eiu_q};
		endcase
	end

	always_comb begin
		if (eiu_q == '0) begin
			n_entries = CW'(1);
		end else if ({2'b00, eiu_q} > 10'(MAX_ENTRIES)) begin
			n_entries = CW'(MAX_ENTRIES);
		end else begin
			n_entries = CW'(eiu_q);
		end
	end

	assign rd_en = (state_q == ST_SCAN) && (cnt_q < n_entries);
	assign age   = now_q - rd_last;

	always_comb begin
		if (hit_found_q) begin
			sel_slot = hit_slot_q;
		end else if (free_found_q) begin
			sel_slot = free_slot_q;
		end else begin
			sel_slot = best_slot_q;
		end
	end

	assign tile_index = (tsc_pkg::TIDX_W'(sel_slot) + tsc_pkg::TIDX_W'(1))
		* tsc_pkg::TIDX_W'(tpg_q);

	assign wr_ctl = '{
		key_en: (state_q == ST_WRITE) && !hit_found_q,
		use_en: (state_q == ST_WRITE)
	};

	tsc_store #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_key  (rd_key),
		.rd_last (rd_last),
		.wr_ctl  (wr_ctl),
		.wr_addr (sel_slot),
		.wr_key  (key_q),
		.wr_last (now_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			valid_q      <= '0;
			key_q        <= '0;
			now_q        <= '0;
			pend_s1      <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			hit_found_q  <= 1'b0;
			hit_slot_q   <= '0;
			free_found_q <= 1'b0;
			free_slot_q  <= '0;
			best_age_q   <= '0;
			best_slot_q  <= '0;
			done_q       <= 1'b0;
			rsp_q        <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.glyph[15]) begin
							rsp_q  <= '0;
							done_q <= 1'b1;
						end else begin
							key_q        <= {req.glyph, req.colour, req.special_flags,
								req.char_code, req.tile_number};
							now_q        <= req.now;
							cnt_q        <= '0;
							pend_s1      <= 1'b0;
							hit_found_q  <= 1'b0;
							free_found_q <= 1'b0;
							best_age_q   <= '0;
							best_slot_q  <= '0;
							state_q      <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					pend_s1 <= rd_en;
					if (rd_en) begin
						vld_s1 <= valid_q[cnt_q[AW-1:0]];
						idx_s1 <= cnt_q[AW-1:0];
						cnt_q  <= cnt_q + CW'(1);
					end else if (!pend_s1) begin
						state_q <= ST_WRITE;
					end
					if (pend_s1) begin
						if (vld_s1) begin
							if (!hit_found_q && rd_key == key_q) begin
								hit_found_q <= 1'b1;
								hit_slot_q  <= idx_s1;
							end
							if (age > best_age_q) begin
								best_age_q  <= age;
								best_slot_q <= idx_s1;
							end
						end else if (!free_found_q) begin
							free_found_q <= 1'b1;
							free_slot_q  <= idx_s1;
						end
					end
				end
				ST_WRITE: begin
					valid_q[sel_slot]   <= 1'b1;
					rsp_q.slot          <= tsc_pkg::SLOT_W'(sel_slot);
					rsp_q.tile_index    <= tile_index;
					rsp_q.hit           <= hit_found_q;
					rsp_q.load_needed   <= !hit_found_q;
					done_q              <= 1'b1;
					state_q             <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_hit_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.hit && rsp.load_needed))
		else $error("hit and load flagged together");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= n_entries))
		else $error("scan counter beyond slots in use");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !req.glyph[15]) |=> busy)
		else $error("request not taken into scan");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (CW'(sel_slot) < n_entries))
		else $error("chosen slot outside slots in use");

	a_empty_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.glyph[15]) |=> (done && !busy && rsp == '0))
		else $error("empty glyph result wrong");

endmodule

// ===== dv/tb_tile_slot_cache.sv =====
// Testbench of the tile slot cache: directed and random requests, LRU slot prediction.
`timescale 1ns / 1ps

module tb_tile_slot_cache;
	import tsc_pkg::*;

	localparam int SLOTS = MAX_ENTRIES_DEF;

	class slot_cache_board;
		bit                valid[SLOTS];
		key_t              keys[SLOTS];
		stamp_t            last_use[SLOTS];
		logic [TPG_W-1:0]  tpg;
		logic [EIU_W-1:0]  eiu;
		rsp_t              due_rsp[$];
		int                mismatches;

		function new();
			tpg = TPG_RESET;
			eiu = EIU_RESET;
			mismatches = 0;
			foreach (valid[i])
				valid[i] = 1'b0;
		endfunction

		function void set_reg(logic idx, logic [DATA_W-1:0] v);
			if (idx == REG_TILES_PER_GLYPH)
				tpg = v[TPG_W-1:0];
			else
				eiu = v[EIU_W-1:0];
		endfunction

		function int active_slots();
			int n;
			n = eiu;
			if (n == 0)
				n = 1;
			if (n > SLOTS)
				n = SLOTS;
			return n;
		endfunction

		function int pending();
			return due_rsp.size();
		endfunction

		function void note_request(req_t r);
			key_t        k;
			int          n, s, best, i;
			bit          hit, found;
			stamp_t      age, best_age;
			rsp_t        e;
			logic [31:0] prod;
			e = '0;
			if (r.glyph[15]) begin
				due_rsp.push_back(e);
				return;
			end
			k = {r.glyph, r.colour, r.special_flags, r.char_code, r.tile_number};
			n = active_slots();
			s = 0;
			hit = 1'b0;
			found = 1'b0;
			for (i = 0; i < n; i++) begin
				if (valid[i] && keys[i] == k) begin
					s = i;
					hit = 1'b1;
					break;
				end
			end
			if (!hit) begin
				best_age = '0;
				best = 0;
				for (i = 0; i < n; i++) begin
					if (!valid[i]) begin
						s = i;
						found = 1'b1;
						break;
					end
					age = r.now - last_use[i];
					if (age > best_age) begin
						best_age = age;
						best = i;
					end
				end
				if (!found)
					s = best;
				valid[s] = 1'b1;
				keys[s] = k;
			end
			last_use[s] = r.now;
			prod = (s + 1) * tpg;
			e.slot = s[SLOT_W-1:0];
			e.tile_index = prod[TIDX_W-1:0];
			e.hit = hit;
			e.load_needed = !hit;
			due_rsp.push_back(e);
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (due_rsp.size() == 0) begin
				$display("%0t result with none due: expected nothing, actual slot %0d index %0d",
					$time, a.slot, a.tile_index);
				mismatches++;
				return;
			end
			e = due_rsp.pop_front();
			cmp_field("slot", e.slot, a.slot);
			cmp_field("tile_index", e.tile_index, a.tile_index);
			cmp_field("hit", e.hit, a.hit);
			cmp_field("load_needed", e.load_needed, a.load_needed);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	req_t              req;
	logic              done;
	rsp_t              rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	slot_cache_board sb;
	key_t            key_pool[$];
	stamp_t          stamp;
	int              sent;

	tile_slot_cache dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	initial begin
		#8_000_000;
		$display("tb_tile_slot_cache failed");
		$finish;
	end

	function automatic req_t mk(int g, int c, int f, int ch, int t, logic [31:0] nw);
		req_t r;
		r.glyph = 16'(g);
		r.colour = 4'(c);
		r.special_flags = 8'(f);
		r.char_code = 8'(ch);
		r.tile_number = 12'(t);
		r.now = nw;
		return r;
	endfunction

	function automatic key_t rand_key();
		return {1'b0, 15'($urandom()), 32'($urandom())};
	endfunction

	task automatic send(input req_t r);
		bit no_idle;
		no_idle = (sent >= 300 && sent < 450);
		while (!no_idle && $urandom_range(99) < 21) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(r);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic configure(input int tpg_v, input int eiu_v);
		drain();
		reg_write(REG_TILES_PER_GLYPH, tpg_v);
		reg_write(REG_ENTRIES_IN_USE, eiu_v);
	endtask

	task automatic directed();
		send(mk(-1, 0, 0, 0, 0, 0));
		send(mk(-32768, 15, 255, 255, 4095, 32'hFFFF_FFFF));
		send(mk(0, 0, 0, 0, 0, 0));
		send(mk(0, 0, 0, 0, 0, 5));
		send(mk(32767, 15, 255, 255, 4095, 32'hFFFF_FFFF));
		send(mk(32767, 15, 255, 255, 4095, 32'hFFFF_FFFF));
		send(mk(32767, 15, 255, 255, 4094, 7));
		configure(31, 2);
		send(mk(1, 1, 1, 1, 1, 100));
		send(mk(2, 2, 2, 2, 2, 100));
		send(mk(3, 3, 3, 3, 3, 100));
		send(mk(-1, 15, 255, 255, 4095, 100));
		configure(0, 0);
		send(mk(4, 4, 4, 4, 4, 200));
		send(mk(4, 4, 4, 4, 4, 201));
		send(mk(5, 5, 5, 5, 5, 201));
		configure(16, 255);
		send(mk(6, 6, 6, 6, 6, 300));
		send(mk(32767, 15, 255, 255, 4094, 301));
	endtask

	task automatic run_phase(input int tpg_v, input int eiu_v, input int count);
		int   n, i, roll;
		key_t k;
		req_t r;
		configure(tpg_v, eiu_v);
		n = sb.active_slots();
		key_pool.delete();
		for (i = 0; i < n + n / 4 + 1; i++)
			key_pool.push_back(rand_key());
		for (i = 0; i < count; i++) begin
			if (i == count / 2)
				drain();
			case ($urandom_range(19))
				0: stamp = $urandom();
				1, 2: ;
				default: stamp += $urandom_range(1, 4);
			endcase
			roll = $urandom_range(99);
			if (roll < 5)
				k = {1'b1, 15'($urandom()), 32'($urandom())};
			else if (roll < 12)
				k = rand_key();
			else
				k = key_pool[$urandom_range(key_pool.size() - 1)];
			r = {k, stamp};
			send(r);
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		stamp = '0;
		arst_n = 1'b0;
		start <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		run_phase(16, 128, 200);
		run_phase(31, 128, 200);
		run_phase(3, 4, 80);
		run_phase(0, 0, 60);
		run_phase(1, 255, 120);
		run_phase(7, 17, 80);
		run_phase(5, 1, 50);
		run_phase($urandom_range(1, 16), $urandom_range(1, 128), 110);
		drain();
		repeat (140) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_tile_slot_cache passed");
		else
			$display("tb_tile_slot_cache failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tsc_pkg.sv
rtl/tsc_store.sv
rtl/tile_slot_cache.sv
dv/tb_tile_slot_cache.sv
